FILE: src/bcm_pkg.sv
// Shared types and constants for the banked cartridge mapper with RTC.
package bcm_pkg;

  localparam int BANK_BYTES    = 8192;
  localparam int BANK_OFF_BITS = 13;
  localparam int ROM_FULL_BITS = 21;
  localparam int RAM_BANKS_DEF = 4;
  localparam int ROM_BITS_DEF  = 21;

  localparam logic [23:0] CPS_RESET      = 24'd4194304;
  localparam logic [2:0]  ROM_CODE_MAX   = 3'd6;
  localparam logic [1:0]  RAM_CODE_RESET = 2'd2;
  localparam logic [1:0]  RAM_CODE_NONE  = 2'd0;
  localparam logic [1:0]  RAM_CODE_ONE   = 2'd1;
  localparam logic [7:0]  ENABLE_ON      = 8'h0A;
  localparam logic [7:0]  ENABLE_OFF     = 8'h00;
  localparam logic [7:0]  DENIED_DATA    = 8'hFF;
  localparam logic [7:0]  SECONDS_WRAP   = 8'd60;
  localparam logic [7:0]  MINUTES_WRAP   = 8'd60;
  localparam logic [7:0]  HOURS_WRAP     = 8'd24;
  localparam logic [9:0]  DAYS_WRAP      = 10'd512;
  localparam logic [24:0] ACC_MAX        = 25'h1FFFFFF;

  localparam logic [7:0] SEL_RTC_FIRST = 8'd8;
  localparam logic [7:0] SEL_RTC_LAST  = 8'd12;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_ROM    = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_DENIED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ROM_SIZE = 2'd0,
    REG_RAM_SIZE = 2'd1,
    REG_CPS      = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    RTC_SEC    = 3'd0,
    RTC_MIN    = 3'd1,
    RTC_HOUR   = 3'd2,
    RTC_DAY_LO = 3'd3,
    RTC_DAY_HI = 3'd4
  } rtc_reg_t;

  typedef enum logic [2:0] {
    WIN_ENABLE = 3'b000,
    WIN_ROMBNK = 3'b001,
    WIN_BNKSEL = 3'b010,
    WIN_EXTRAM = 3'b101
  } win_t;

  typedef struct packed {
    logic       tick;
    logic [7:0] cycles;
    logic       wr;
    rtc_reg_t   sel;
    logic [7:0] data;
  } rtc_req_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       use_ram;
    logic       ram_en;
  } s1_t;

endpackage

FILE: src/banked_cartridge_mapper_rtc.sv
// Top level of the banked cartridge mapper with real-time clock.
// An accepted input is registered into s1 (decode, RAM read), then into the output registers.
// Throughput: one item per cycle while in_stall is low; the banked RAM has one write port and one read port.
// Writes land at the input transfer edge, so a following read sees them with no interlock.
// Reset (rst, synchronous): mapper, RTC and config registers take their reset values;
// banked RAM contents are undefined until written and get no clearing pass.
module banked_cartridge_mapper_rtc
  import bcm_pkg::*;
#(
  parameter int RAM_BANKS     = RAM_BANKS_DEF,
  parameter int ROM_ADDR_BITS = ROM_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [23:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               command,
  input  logic [15:0]              address,
  input  logic [7:0]               write_data,
  input  logic [7:0]               tick_cycles,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               result_kind,
  output logic [ROM_ADDR_BITS-1:0] rom_address,
  output logic [7:0]               read_data,
  output logic                     ram_enabled
);

  localparam int RAM_DEPTH = RAM_BANKS * BANK_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  logic [2:0]  rom_size_code;
  logic [1:0]  ram_size_code;
  logic [23:0] cycles_per_second;

  logic [6:0] rom_bank, rom_bank_next;
  logic [7:0] bank_select, bank_select_next;
  logic       enable_latch, enable_latch_next;

  logic       in_fire;
  logic       s1_valid;
  logic       s1_adv;
  s1_t        s1, s1_next;
  logic [ROM_ADDR_BITS-1:0] s1_rom, s1_rom_next;

  logic [2:0]  rom_code;
  logic [6:0]  bank_mask;
  logic [ROM_FULL_BITS-1:0] rom_full;
  logic [2:0]  banks_present;
  logic        ram_sel_ok;
  logic        rtc_sel_ok;
  logic [BANK_OFF_BITS+1:0] ram_full;
  logic [RAM_AW-1:0] ram_addr;
  logic        ram_we;
  logic [7:0]  ram_rdata;
  rtc_req_t    rtc_req, rtc_req_q;
  logic [7:0]  rtc_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size_code     <= '0;
      ram_size_code     <= RAM_CODE_RESET;
      cycles_per_second <= CPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROM_SIZE: rom_size_code <= cfg_data[2:0];
        REG_RAM_SIZE: ram_size_code <= cfg_data[1:0];
        REG_CPS:      cycles_per_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign s1_adv   = s1_valid && !(out_valid && out_stall);

  assign rom_code  = (rom_size_code > ROM_CODE_MAX) ? ROM_CODE_MAX : rom_size_code;
  assign bank_mask = 7'((8'd2 << rom_code) - 8'd1);
  assign rom_full  = address[14] ? {rom_bank & bank_mask, address[13:0]}
                                 : {7'd0, address[13:0]};

  always_comb begin
    case (ram_size_code)
      RAM_CODE_NONE: banks_present = 3'd0;
      RAM_CODE_ONE:  banks_present = 3'd1;
      default:       banks_present = 3'(RAM_BANKS);
    endcase
  end

  assign ram_sel_ok = (bank_select[7:2] == 6'd0) && ({1'b0, bank_select[1:0]} < banks_present);
  assign rtc_sel_ok = bank_select inside {[SEL_RTC_FIRST:SEL_RTC_LAST]};
  assign ram_full   = {bank_select[1:0], address[BANK_OFF_BITS-1:0]};
  assign ram_addr   = ram_full[RAM_AW-1:0];

  always_comb begin
    rom_bank_next     = rom_bank;
    bank_select_next  = bank_select;
    enable_latch_next = enable_latch;
    ram_we            = 1'b0;
    rtc_req           = '0;
    rtc_req.sel       = rtc_reg_t'(bank_select[2:0]);
    rtc_req.data      = write_data;
    rtc_req.cycles    = tick_cycles;
    s1_rom_next       = '0;
    s1_next.kind      = KIND_DONE;
    s1_next.data      = 8'd0;
    s1_next.use_ram   = 1'b0;
    case (command)
      CMD_READ: begin
        if (!address[15]) begin
          s1_next.kind = KIND_ROM;
          s1_rom_next  = rom_full[ROM_ADDR_BITS-1:0];
        end else if (address[15:13] == WIN_EXTRAM && ram_sel_ok) begin
          s1_next.kind    = KIND_DATA;
          s1_next.use_ram = 1'b1;
        end else if (address[15:13] == WIN_EXTRAM && rtc_sel_ok) begin
          s1_next.kind = KIND_DATA;
          s1_next.data = rtc_rdata;
        end else begin
          s1_next.kind = KIND_DENIED;
          s1_next.data = DENIED_DATA;
        end
      end
      CMD_WRITE: begin
        case (address[15:13])
          WIN_ENABLE: begin
            if (write_data == ENABLE_ON) begin
              enable_latch_next = 1'b1;
            end else if (write_data == ENABLE_OFF) begin
              enable_latch_next = 1'b0;
            end
          end
          WIN_ROMBNK: begin
            rom_bank_next = (write_data[6:0] == 7'd0) ? 7'd1 : write_data[6:0];
          end
          WIN_BNKSEL: bank_select_next = write_data;
          WIN_EXTRAM: begin
            if (ram_sel_ok) begin
              ram_we = 1'b1;
            end else if (rtc_sel_ok) begin
              rtc_req.wr = 1'b1;
            end else begin
              s1_next.kind = KIND_DENIED;
              s1_next.data = DENIED_DATA;
            end
          end
          default: ;
        endcase
      end
      CMD_TICK: rtc_req.tick = 1'b1;
      default: begin
        s1_next.kind = KIND_DENIED;
        s1_next.data = DENIED_DATA;
      end
    endcase
    s1_next.ram_en = enable_latch_next;
  end

  always_comb begin
    rtc_req_q      = rtc_req;
    rtc_req_q.tick = rtc_req.tick && in_fire;
    rtc_req_q.wr   = rtc_req.wr && in_fire;
  end

  bcm_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (in_fire && ram_we),
    .waddr (ram_addr),
    .wdata (write_data),
    .re    (in_fire),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  bcm_rtc u_rtc (
    .clk     (clk),
    .rst     (rst),
    .req     (rtc_req_q),
    .cps     (cycles_per_second),
    .rd_sel  (rtc_reg_t'(bank_select[2:0])),
    .rd_data (rtc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank     <= 7'd1;
      bank_select  <= '0;
      enable_latch <= 1'b0;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        rom_bank     <= rom_bank_next;
        bank_select  <= bank_select_next;
        enable_latch <= enable_latch_next;
        s1_valid     <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1     <= s1_next;
      s1_rom <= s1_rom_next;
    end
    if (s1_adv) begin
      result_kind <= s1.kind;
      rom_address <= s1_rom;
      read_data   <= s1.use_ram ? ram_rdata : s1.data;
      ram_enabled <= s1.ram_en;
    end
  end

endmodule

FILE: src/bcm_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
module bcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bcm_rtc.sv
// Real-time clock: cycle accumulator, time counters and register access.
module bcm_rtc
  import bcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rtc_req_t    req,
  input  logic [23:0] cps,
  input  rtc_reg_t    rd_sel,
  output logic [7:0]  rd_data
);

  logic [7:0]  seconds, seconds_next;
  logic [7:0]  minutes, minutes_next;
  logic [7:0]  hours, hours_next;
  logic [8:0]  days, days_next;
  logic        halt_flag, halt_flag_next;
  logic        day_overflow, day_overflow_next;
  logic [24:0] acc, acc_next;

  logic [25:0] acc_sum;
  logic [24:0] acc_sat;
  logic [24:0] cps_eff;
  logic [9:0]  days_inc;

  always_comb begin
    seconds_next      = seconds;
    minutes_next      = minutes;
    hours_next        = hours;
    days_next         = days;
    halt_flag_next    = halt_flag;
    day_overflow_next = day_overflow;
    acc_next          = acc;
    acc_sum  = {1'b0, acc} + {18'd0, req.cycles};
    acc_sat  = acc_sum[25] ? ACC_MAX : acc_sum[24:0];
    cps_eff  = (cps == 24'd0) ? 25'd1 : {1'b0, cps};
    days_inc = {1'b0, days} + 10'd1;

    if (req.tick) begin
      acc_next = acc_sat;
      if (acc_sat >= cps_eff) begin
        acc_next     = acc_sat - cps_eff;
        seconds_next = seconds + 8'd1;
        if (seconds_next == SECONDS_WRAP) begin
          seconds_next = 8'd0;
          minutes_next = minutes + 8'd1;
          if (minutes_next == MINUTES_WRAP) begin
            minutes_next = 8'd0;
            hours_next   = hours + 8'd1;
            if (hours_next == HOURS_WRAP) begin
              hours_next = 8'd0;
              days_next  = days_inc[8:0];
              if (days_inc == DAYS_WRAP) begin
                days_next         = 9'd0;
                day_overflow_next = 1'b1;
              end
            end
          end
        end
      end
    end else if (req.wr) begin
      case (req.sel)
        RTC_SEC:    seconds_next = req.data;
        RTC_MIN:    minutes_next = req.data;
        RTC_HOUR:   hours_next = req.data;
        RTC_DAY_LO: days_next = {days[8], req.data};
        RTC_DAY_HI: begin
          days_next         = {req.data[0], days[7:0]};
          halt_flag_next    = req.data[6];
          day_overflow_next = req.data[7];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds      <= '0;
      minutes      <= '0;
      hours        <= '0;
      days         <= '0;
      halt_flag    <= 1'b0;
      day_overflow <= 1'b0;
      acc          <= '0;
    end else begin
      seconds      <= seconds_next;
      minutes      <= minutes_next;
      hours        <= hours_next;
      days         <= days_next;
      halt_flag    <= halt_flag_next;
      day_overflow <= day_overflow_next;
      acc          <= acc_next;
    end
  end

  always_comb begin
    case (rd_sel)
      RTC_SEC:    rd_data = seconds;
      RTC_MIN:    rd_data = minutes;
      RTC_HOUR:   rd_data = hours;
      RTC_DAY_LO: rd_data = days[7:0];
      RTC_DAY_HI: rd_data = {day_overflow, halt_flag, 5'd0, days[8]};
      default:    rd_data = 8'd0;
    endcase
  end

endmodule

FILE: src/bcm_check.sv
// Port-level checker for the cartridge mapper, bound to the top level.
module bcm_check
  import bcm_pkg::*;
#(
  parameter int ROM_ADDR_BITS = ROM_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               result_kind,
  input logic [ROM_ADDR_BITS-1:0] rom_address,
  input logic [7:0]               read_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(read_data))
    else $error("result changed while stalled");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_denied_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_DENIED |-> read_data == DENIED_DATA)
    else $error("denied access without 0xFF data");

  a_rom_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_ROM |-> rom_address == '0)
    else $error("ROM address set on non-ROM result");

  a_done_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_DONE || result_kind == KIND_ROM) |-> read_data == 8'd0)
    else $error("read data set on result without data");

endmodule

bind banked_cartridge_mapper_rtc bcm_check #(
  .ROM_ADDR_BITS(ROM_ADDR_BITS)
) u_bcm_check (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_kind (result_kind),
  .rom_address (rom_address),
  .read_data   (read_data)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the banked cartridge mapper with RTC: directed and random bus traffic vs. predictor.
module testbench;
  import bcm_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [7:0] SEL_SEC    = SEL_RTC_FIRST + 8'(RTC_SEC);
  localparam logic [7:0] SEL_MIN    = SEL_RTC_FIRST + 8'(RTC_MIN);
  localparam logic [7:0] SEL_HOUR   = SEL_RTC_FIRST + 8'(RTC_HOUR);
  localparam logic [7:0] SEL_DAY_LO = SEL_RTC_FIRST + 8'(RTC_DAY_LO);
  localparam logic [7:0] SEL_DAY_HI = SEL_RTC_FIRST + 8'(RTC_DAY_HI);
  localparam logic [7:0] NEAR_WRAP [4] = '{8'd59, 8'd23, 8'd60, 8'd255};
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SOAK_TICKS  = 60;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  tick_cycles;
  } bus_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [20:0] rom_addr;
    logic [7:0]  data;
    logic        en;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [23:0] cfg_data = 24'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = 2'd0;
  logic [15:0] address = 16'd0;
  logic [7:0]  write_data = 8'd0;
  logic [7:0]  tick_cycles = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [20:0] rom_address;
  logic [7:0]  read_data;
  logic        ram_enabled;

  bus_item_t   bus_items [$];
  bus_result_t due_results [$];
  bus_item_t   next_item;
  bus_result_t expected;
  int          pushed_count = 0;
  int          loaded_count = 0;
  int          accepted_count = 0;
  int          errors = 0;
  int          tb_cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_input = 1'b0;

  // stimulus-side view, used to keep reads off unwritten RAM and to pick RTC write values
  logic [7:0]  gen_sel = 8'd0;
  logic [1:0]  gen_ram_code = RAM_CODE_RESET;
  bit          gen_written [0:32767];

  // predicted mapper state
  logic [2:0]  sh_rom_code = 3'd0;
  logic [1:0]  sh_ram_code = RAM_CODE_RESET;
  logic [23:0] sh_cps = CPS_RESET;
  logic [6:0]  sh_rom_bank = 7'd1;
  logic [7:0]  sh_sel = 8'd0;
  logic        sh_en = 1'b0;
  logic [7:0]  sh_ram [0:32767];
  logic [7:0]  rtc_sec = 8'd0;
  logic [7:0]  rtc_min = 8'd0;
  logic [7:0]  rtc_hour = 8'd0;
  logic [8:0]  rtc_days = 9'd0;
  logic        rtc_stop = 1'b0;
  logic        rtc_ovf = 1'b0;
  logic [24:0] cyc_acc = 25'd0;

  banked_cartridge_mapper_rtc uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .address(address),
    .write_data(write_data), .tick_cycles(tick_cycles),
    .out_valid(out_valid), .out_stall(out_stall), .result_kind(result_kind),
    .rom_address(rom_address), .read_data(read_data), .ram_enabled(ram_enabled)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] banks_for(logic [1:0] code);
    if (code == RAM_CODE_NONE) return 8'd0;
    if (code == RAM_CODE_ONE) return 8'd1;
    return 8'(RAM_BANKS_DEF);
  endfunction

  function automatic bus_result_t mapper_step(logic [1:0] cmd, logic [15:0] a, logic [7:0] wd,
                                              logic [7:0] tc);
    bus_result_t r;
    logic [2:0]  code;
    logic [6:0]  bmask;
    logic [25:0] sum;
    logic [23:0] cps;
    logic [9:0]  day_next;
    logic [14:0] slot;
    logic        sel_ok;
    r = '0;
    r.kind = KIND_DONE;
    slot = {sh_sel[1:0], a[12:0]};
    sel_ok = (sh_sel < 4) ? (sh_sel < banks_for(sh_ram_code))
                          : (sh_sel >= SEL_RTC_FIRST && sh_sel <= SEL_RTC_LAST);
    case (cmd)
      CMD_READ: begin
        if (!a[15]) begin
          r.kind = KIND_ROM;
          code = (sh_rom_code > ROM_CODE_MAX) ? ROM_CODE_MAX : sh_rom_code;
          bmask = 7'((8'd2 << code) - 8'd1);
          r.rom_addr = a[14] ? {sh_rom_bank & bmask, a[13:0]} : {7'd0, a[13:0]};
        end else if (a[15:13] == WIN_EXTRAM && sel_ok) begin
          r.kind = KIND_DATA;
          if (sh_sel < 4) r.data = sh_ram[slot];
          else if (sh_sel == SEL_SEC) r.data = rtc_sec;
          else if (sh_sel == SEL_MIN) r.data = rtc_min;
          else if (sh_sel == SEL_HOUR) r.data = rtc_hour;
          else if (sh_sel == SEL_DAY_LO) r.data = rtc_days[7:0];
          else r.data = {rtc_ovf, rtc_stop, 5'd0, rtc_days[8]};
        end else begin
          r.kind = KIND_DENIED;
          r.data = DENIED_DATA;
        end
      end
      CMD_WRITE: begin
        case (a[15:13])
          WIN_ENABLE: begin
            if (wd == ENABLE_ON) sh_en = 1'b1;
            else if (wd == ENABLE_OFF) sh_en = 1'b0;
          end
          WIN_ROMBNK: sh_rom_bank = (wd[6:0] == 7'd0) ? 7'd1 : wd[6:0];
          WIN_BNKSEL: sh_sel = wd;
          WIN_EXTRAM: begin
            if (!sel_ok) begin
              r.kind = KIND_DENIED;
              r.data = DENIED_DATA;
            end else if (sh_sel < 4) sh_ram[slot] = wd;
            else if (sh_sel == SEL_SEC) rtc_sec = wd;
            else if (sh_sel == SEL_MIN) rtc_min = wd;
            else if (sh_sel == SEL_HOUR) rtc_hour = wd;
            else if (sh_sel == SEL_DAY_LO) rtc_days[7:0] = wd;
            else begin
              rtc_days[8] = wd[0];
              rtc_stop = wd[6];
              rtc_ovf = wd[7];
            end
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        cps = (sh_cps == 24'd0) ? 24'd1 : sh_cps;
        sum = {1'b0, cyc_acc} + 26'(tc);
        if (sum > 26'(ACC_MAX)) sum = 26'(ACC_MAX);
        if (sum >= 26'(cps)) begin
          sum = sum - 26'(cps);
          rtc_sec = rtc_sec + 8'd1;
          if (rtc_sec == SECONDS_WRAP) begin
            rtc_sec = 8'd0;
            rtc_min = rtc_min + 8'd1;
            if (rtc_min == MINUTES_WRAP) begin
              rtc_min = 8'd0;
              rtc_hour = rtc_hour + 8'd1;
              if (rtc_hour == HOURS_WRAP) begin
                rtc_hour = 8'd0;
                day_next = {1'b0, rtc_days} + 10'd1;
                if (day_next == DAYS_WRAP) begin
                  day_next = 10'd0;
                  rtc_ovf = 1'b1;
                end
                rtc_days = day_next[8:0];
              end
            end
          end
        end
        cyc_acc = sum[24:0];
      end
      default: begin
        r.kind = KIND_DENIED;
        r.data = DENIED_DATA;
      end
    endcase
    r.en = sh_en;
    return r;
  endfunction

  function automatic logic [12:0] ram_offset();
    if ($urandom_range(0, 4) == 0) return 13'($urandom);
    return $urandom_range(0, 1) ? 13'($urandom_range(0, 15)) : 13'h1FF0 + 13'($urandom_range(0, 15));
  endfunction

  function automatic bus_item_t random_item();
    bus_item_t   it;
    int unsigned pick;
    it.address = 16'($urandom);
    it.write_data = 8'($urandom);
    it.tick_cycles = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) it.command = CMD_UNKNOWN;
    else if (pick < 20) it.command = CMD_TICK;
    else if (pick < 55) begin
      it.command = CMD_READ;
      pick = $urandom_range(0, 9);
      if (pick < 4) it.address[15] = 1'b0;
      else if (pick < 8) it.address = {WIN_EXTRAM, ram_offset()};
    end else begin
      it.command = CMD_WRITE;
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          it.address[15:13] = WIN_ENABLE;
          pick = $urandom_range(0, 2);
          if (pick == 0) it.write_data = ENABLE_ON;
          else if (pick == 1) it.write_data = ENABLE_OFF;
        end
        1: it.address[15:13] = WIN_ROMBNK;
        2, 3: begin
          it.address[15:13] = WIN_BNKSEL;
          pick = $urandom_range(0, 9);
          if (pick < 6) it.write_data = 8'($urandom_range(0, 3));
          else if (pick < 9) it.write_data = 8'($urandom_range(SEL_RTC_FIRST, SEL_RTC_LAST));
        end
        9: ;
        default: begin
          it.address = {WIN_EXTRAM, ram_offset()};
          if (gen_sel >= SEL_SEC && gen_sel <= SEL_DAY_LO && $urandom_range(0, 1))
            it.write_data = NEAR_WRAP[2'($urandom_range(0, 3))];
        end
      endcase
    end
    return it;
  endfunction

  // reads of RAM never written are turned into writes
  task automatic queue_item(bus_item_t it);
    logic [14:0] slot;
    logic        ram_hit;
    slot = {gen_sel[1:0], it.address[12:0]};
    ram_hit = it.address[15:13] == WIN_EXTRAM && gen_sel < 4 && gen_sel < banks_for(gen_ram_code);
    if (it.command == CMD_READ && ram_hit && !gen_written[slot]) it.command = CMD_WRITE;
    if (it.command == CMD_WRITE && ram_hit) gen_written[slot] = 1'b1;
    if (it.command == CMD_WRITE && it.address[15:13] == WIN_BNKSEL) gen_sel = it.write_data;
    bus_items.push_back(it);
    pushed_count++;
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROM_SIZE: sh_rom_code = val[2:0];
      REG_RAM_SIZE: begin
        sh_ram_code = val[1:0];
        gen_ram_code = val[1:0];
      end
      default: sh_cps = val;
    endcase
  endtask

  task automatic configure(logic [2:0] rom_code, logic [1:0] ram_code, logic [23:0] cps);
    set_reg(REG_ROM_SIZE, 24'(rom_code));
    set_reg(REG_RAM_SIZE, 24'(ram_code));
    set_reg(REG_CPS, cps);
  endtask

  task automatic settle();
    while (accepted_count != pushed_count || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int idle, int stall, int n, bit pressure);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) queue_item(random_item());
    if (pressure) begin
      while (accepted_count < pushed_count - n / 2) @(posedge clk);
      hold_input = 1'b1;
      while (accepted_count != loaded_count || due_results.size() != 0) @(posedge clk);
      repeat (3) @(posedge clk);
      hold_input = 1'b0;
    end
    settle();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(mapper_step(command, address, write_data, tick_cycles));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (!hold_input && bus_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          next_item = bus_items.pop_front();
          command <= next_item.command;
          address <= next_item.address;
          write_data <= next_item.write_data;
          tick_cycles <= next_item.tick_cycles;
          in_valid <= 1'b1;
          loaded_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing outstanding");
          errors++;
        end else begin
          expected = due_results.pop_front();
          if (result_kind !== expected.kind) begin
            $error("result_kind: expected %0d, got %0d", expected.kind, result_kind);
            errors++;
          end
          if (rom_address !== expected.rom_addr) begin
            $error("rom_address: expected %0h, got %0h", expected.rom_addr, rom_address);
            errors++;
          end
          if (read_data !== expected.data) begin
            $error("read_data: expected %0h, got %0h", expected.data, read_data);
            errors++;
          end
          if (ram_enabled !== expected.en) begin
            $error("ram_enabled: expected %0b, got %0b", expected.en, ram_enabled);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    tb_cycles++;
    if (tb_cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    configure(ROM_CODE_MAX, RAM_CODE_RESET, 24'd1);
    queue_item('{CMD_WRITE, 16'h0000, ENABLE_ON, 8'd0});
    queue_item('{CMD_WRITE, 16'h1FFF, 8'h55, 8'd0});        // neither on nor off: latch holds
    queue_item('{CMD_WRITE, 16'h2000, 8'h00, 8'd0});        // bank 0 maps to 1
    queue_item('{CMD_READ, 16'h7FFF, 8'd0, 8'd0});
    queue_item('{CMD_WRITE, 16'h3FFF, 8'hFF, 8'd0});
    queue_item('{CMD_READ, 16'h4000, 8'd0, 8'd0});
    queue_item('{CMD_READ, 16'h0000, 8'd0, 8'd0});
    queue_item('{CMD_WRITE, 16'h4000, 8'h00, 8'd0});
    queue_item('{CMD_WRITE, 16'hBFFF, 8'hFF, 8'd0});
    queue_item('{CMD_READ, 16'hBFFF, 8'd0, 8'd0});
    queue_item('{CMD_WRITE, 16'h5FFF, 8'h07, 8'd0});        // select with nothing behind it
    queue_item('{CMD_READ, 16'hA000, 8'd0, 8'd0});
    queue_item('{CMD_WRITE, 16'hA000, 8'h12, 8'd0});
    // park the clock one second before the day counter wraps
    queue_item('{CMD_WRITE, 16'h4000, SEL_SEC, 8'd0});
    queue_item('{CMD_WRITE, 16'hA000, 8'd59, 8'd0});
    queue_item('{CMD_WRITE, 16'h4000, SEL_MIN, 8'd0});
    queue_item('{CMD_WRITE, 16'hA000, 8'd59, 8'd0});
    queue_item('{CMD_WRITE, 16'h4000, SEL_HOUR, 8'd0});
    queue_item('{CMD_WRITE, 16'hA000, 8'd23, 8'd0});
    queue_item('{CMD_WRITE, 16'h4000, SEL_DAY_LO, 8'd0});
    queue_item('{CMD_WRITE, 16'hA000, 8'hFF, 8'd0});
    queue_item('{CMD_WRITE, 16'h4000, SEL_DAY_HI, 8'd0});
    queue_item('{CMD_WRITE, 16'hA000, 8'h41, 8'd0});
    queue_item('{CMD_TICK, 16'h0000, 8'd0, 8'd0});
    queue_item('{CMD_TICK, 16'h0000, 8'd0, 8'd255});
    queue_item('{CMD_READ, 16'hA000, 8'd0, 8'd0});
    queue_item('{CMD_READ, 16'hFFFF, 8'd0, 8'd0});
    queue_item('{CMD_WRITE, 16'hC000, 8'hAA, 8'd0});
    queue_item('{CMD_WRITE, 16'h6000, 8'h01, 8'd0});
    queue_item('{CMD_UNKNOWN, 16'hA000, 8'hFF, 8'hFF});
    queue_item('{CMD_WRITE, 16'h0000, ENABLE_OFF, 8'd0});
    settle();

    configure(3'd0, RAM_CODE_ONE, 24'd1);
    run_phase(0, 0, PHASE_ITEMS, 1'b0);
    configure(3'd7, 2'd3, 24'd3);
    run_phase(71, 0, PHASE_ITEMS, 1'b0);
    configure(3'd3, RAM_CODE_NONE, 24'd0);
    run_phase(0, 71, PHASE_ITEMS, 1'b0);
    configure(ROM_CODE_MAX, RAM_CODE_RESET, 24'hFFFFFF);
    run_phase(10, 10, PHASE_ITEMS, 1'b0);
    configure(3'd1, RAM_CODE_RESET, 24'd200);
    run_phase(0, 0, PHASE_ITEMS, 1'b1);

    // back-to-back full ticks, one second each, accumulator growing every tick
    configure(3'd2, RAM_CODE_ONE, 24'd1);
    idle_pct = 0;
    stall_pct = 0;
    repeat (SOAK_TICKS) queue_item('{CMD_TICK, 16'h0000, 8'd0, 8'd255});
    settle();
    run_phase(10, 10, 40, 1'b0);

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
